// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
`define ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(name, clk, rst_n, pre, post)
`define ASSERT_NEXT(name, clk, rst_n, pre, post)
`endif
`endif

// ===== design/gcd_pkg.sv =====
// Types and constants of the great-circle distance pipeline.
`timescale 1ns / 1ps
package gcd_pkg;

    localparam int NSTEPS     = 32;
    localparam int SQRT_STEPS = 31;
    localparam int PH_LAT     = 4;
    localparam int MUL_STAGES = 6;
    localparam int FIN_STAGES = 2;
    localparam int LAT = PH_LAT + NSTEPS + MUL_STAGES + SQRT_STEPS + NSTEPS + FIN_STAGES;
    localparam int SQRT_DONE = PH_LAT + NSTEPS + MUL_STAGES + SQRT_STEPS - 1;

    localparam int CW  = 34;
    localparam int SQW = 62;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [60:0] ONE_Q60  = {1'b1, 60'd0};
    localparam logic [30:0] CIRC_X4  = 31'd1603000667;
    localparam logic [27:0] DIST_MAX = 28'd200375083;
    localparam logic [SQW-1:0] ROOT_MAX = {{(SQW-31){1'b0}}, 1'b1, 30'd0};

    localparam logic [21:0] PH_DIV   = 22'd3515625;
    localparam logic [31:0] PH_RECIP = 32'd2562047788;
    localparam logic [20:0] PH_HALF  = 21'd1757812;

    localparam logic [29:0] ATAN_TAB [0:NSTEPS-1] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
        30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
        30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
        30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
    };

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_cordic;

    typedef struct packed {
        logic [SQW-1:0] n;
        logic [SQW-1:0] r;
    } t_sqrt;

endpackage

// ===== design/gcd_phase.sv =====
// Converts a signed angle in 1e-7 degree (times two to the 31) into a binary phase.
`timescale 1ns / 1ps
module gcd_phase (
    input  logic                          i_clk,
    input  logic signed [gcd_pkg::CW-1:0] i_d,
    output logic [31:0]                   o_phase
);

    logic [32:0] r_m, n_m;
    logic        r_neg0, n_neg0;
    logic [32:0] r_q0, n_q0;
    logic [23:0] r_blow, n_blow;
    logic        r_neg1, n_neg1;
    logic [32:0] r_q1, n_q1;
    logic [23:0] r_rem, n_rem;
    logic        r_neg2, n_neg2;
    logic [31:0] r_phase, n_phase;
    logic [64:0] prod;
    logic [45:0] qd;
    logic [1:0]  cnt;
    logic [31:0] p;

    always_comb begin
        n_neg0 = i_d[gcd_pkg::CW-1];
        n_m    = n_neg0 ? 33'(-i_d) : 33'(i_d);

        prod   = 65'(r_m) * 65'(gcd_pkg::PH_RECIP);
        n_q0   = prod[64:32];
        n_blow = {r_m[2:0], gcd_pkg::PH_HALF};
        n_neg1 = r_neg0;

        qd     = 46'(r_q0[23:0]) * 46'(gcd_pkg::PH_DIV);
        n_rem  = r_blow - qd[23:0];
        n_q1   = r_q0;
        n_neg2 = r_neg1;

        cnt = 2'd0;
        if (r_rem >= 24'(gcd_pkg::PH_DIV)) begin
            cnt = 2'd1;
        end
        if (r_rem >= 24'(2 * gcd_pkg::PH_DIV)) begin
            cnt = 2'd2;
        end
        if (r_rem >= 24'(3 * gcd_pkg::PH_DIV)) begin
            cnt = 2'd3;
        end
        p       = r_q1[31:0] + 32'(cnt);
        n_phase = r_neg2 ? (32'd0 - p) : p;
    end

    always_ff @(posedge i_clk) begin
        r_m     <= n_m;
        r_neg0  <= n_neg0;
        r_q0    <= n_q0;
        r_blow  <= n_blow;
        r_neg1  <= n_neg1;
        r_q1    <= n_q1;
        r_rem   <= n_rem;
        r_neg2  <= n_neg2;
        r_phase <= n_phase;
    end

    assign o_phase = r_phase;

endmodule

// ===== design/gcd_cordic_cell.sv =====
// One CORDIC micro-rotation cell, in rotation or vectoring mode.
`timescale 1ns / 1ps
module gcd_cordic_cell (
    input  logic             i_clk,
    input  logic             i_vectoring,
    input  logic [4:0]       i_shift,
    input  logic [29:0]      i_atan,
    input  gcd_pkg::t_cordic i_data,
    output gcd_pkg::t_cordic o_data
);

    logic signed [gcd_pkg::CW-1:0] x, y, z, xs, ys, at;
    logic                          up;
    gcd_pkg::t_cordic              r_data, n_data;

    always_comb begin
        x  = i_data.x;
        y  = i_data.y;
        z  = i_data.z;
        xs = x >>> i_shift;
        ys = y >>> i_shift;
        at = $signed({{(gcd_pkg::CW-30){1'b0}}, i_atan});
        up = i_vectoring ? y[gcd_pkg::CW-1] : !z[gcd_pkg::CW-1];
        if (up) begin
            n_data.x = x - ys;
            n_data.y = y + xs;
            n_data.z = z - at;
        end else begin
            n_data.x = x + ys;
            n_data.y = y - xs;
            n_data.z = z + at;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== design/gcd_sqrt_cell.sv =====
// One bit-pair step of the integer square root.
`timescale 1ns / 1ps
module gcd_sqrt_cell (
    input  logic           i_clk,
    input  logic [4:0]     i_step,
    input  gcd_pkg::t_sqrt i_data,
    output gcd_pkg::t_sqrt o_data
);

    logic [gcd_pkg::SQW-1:0] bitv, sum;
    gcd_pkg::t_sqrt          r_data, n_data;

    always_comb begin
        bitv = {{(gcd_pkg::SQW-1){1'b0}}, 1'b1} << {i_step, 1'b0};
        sum  = i_data.r + bitv;
        if (i_data.n >= sum) begin
            n_data.n = i_data.n - sum;
            n_data.r = (i_data.r >> 1) + bitv;
        end else begin
            n_data.n = i_data.n;
            n_data.r = i_data.r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== design/great_circle_distance_top.sv =====
// Top level of the pipelined haversine great-circle distance block.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Usage:
// An item is a base and a target position, each a latitude and longitude in
// signed units of 1e-7 degree. A transfer in happens at a rising edge with
// start high and busy low; busy is always low, so one item can enter in
// every cycle. Each item produces exactly one distance in units of 0.1 m,
// rounded to nearest, on o_distance for one cycle with o_valid high.
// An item passes in order through phase conversion, 32 rotation CORDIC
// cells, 6 multiply and clamp stages, 31 square-root cells, 32 vectoring
// CORDIC cells and the final scaling. Throughput is one item per cycle.
// Results leave in input order. The receiver cannot stall, so results are
// never held back. A synchronous active-low reset clears all valid flags;
// items in flight are dropped and no result appears until new items arrive.
module great_circle_distance_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [30:0] i_base_latitude,
    input  logic signed [31:0] i_base_longitude,
    input  logic signed [30:0] i_target_latitude,
    input  logic signed [31:0] i_target_longitude,
    output logic               o_valid,
    output logic [27:0]        o_distance
);

    localparam int CW = gcd_pkg::CW;

    logic [gcd_pkg::LAT-1:0] r_vld, n_vld;

    logic signed [CW-1:0] lane_d [0:3];
    logic [31:0]          phase [0:3];
    logic [3:0]           flip;
    gcd_pkg::t_cordic     rot_d [0:3][0:gcd_pkg::NSTEPS];
    logic [1:0]           r_flip [0:gcd_pkg::NSTEPS-1];
    logic [1:0]           n_flip;

    logic [31:0] r_mc1, r_mc2, r_msa, r_msb;
    logic        r_neg0;
    logic [31:0] n_mc1, n_mc2, n_msa, n_msb;
    logic        n_neg0;
    logic        negc1, negc2;
    logic [CW-1:0] c1, c2, sa, sb;

    logic [63:0] r_s1sq1, r_ccf, n_s1sq1, n_ccf;
    logic [31:0] r_sbm1, r_sbm2;
    logic        r_neg1, r_neg2, r_neg3;
    logic [63:0] t1p;
    logic [31:0] r_t1, n_t1;
    logic [63:0] r_s1sq2, r_s1sq3, r_term, n_term;
    logic signed [65:0] hs;
    logic [60:0] r_h, n_h;
    logic [gcd_pkg::SQW-1:0] r_ny, r_nx, n_ny, n_nx;

    gcd_pkg::t_sqrt   sq_y [0:gcd_pkg::SQRT_STEPS];
    gcd_pkg::t_sqrt   sq_x [0:gcd_pkg::SQRT_STEPS];
    gcd_pkg::t_cordic vec_d [0:gcd_pkg::NSTEPS];

    logic signed [CW-1:0] zv;
    logic [30:0] zc;
    logic [61:0] r_prod, n_prod, fsum;
    logic [27:0] r_dist, n_dist;

    assign busy = 1'b0;

    always_comb begin
        lane_d[0] = {{2{i_base_latitude[30]}}, i_base_latitude, 1'b0};
        lane_d[1] = {{2{i_target_latitude[30]}}, i_target_latitude, 1'b0};
        lane_d[2] = CW'(i_base_latitude) - CW'(i_target_latitude);
        lane_d[3] = CW'(i_base_longitude) - CW'(i_target_longitude);
    end

    for (genvar l = 0; l < 4; l++) begin : g_lane
        logic [31:0] pq, pp;

        gcd_phase u_phase (
            .i_clk  (i_clk),
            .i_d    (lane_d[l]),
            .o_phase(phase[l])
        );

        always_comb begin
            pq      = phase[l] + 32'h4000_0000;
            flip[l] = pq[31];
            pp      = flip[l] ? (phase[l] + 32'h8000_0000) : phase[l];
            rot_d[l][0].x = gcd_pkg::CORDIC_GAIN;
            rot_d[l][0].y = '0;
            rot_d[l][0].z = {{(CW-32){pp[31]}}, pp};
        end

        for (genvar k = 0; k < gcd_pkg::NSTEPS; k++) begin : g_rot
            gcd_cordic_cell u_cell (
                .i_clk      (i_clk),
                .i_vectoring(1'b0),
                .i_shift    (5'(k)),
                .i_atan     (gcd_pkg::ATAN_TAB[k]),
                .i_data     (rot_d[l][k]),
                .o_data     (rot_d[l][k+1])
            );
        end
    end

    assign n_flip = flip[1:0];

    always_ff @(posedge i_clk) begin
        r_flip[0] <= n_flip;
        for (int k = 1; k < gcd_pkg::NSTEPS; k++) begin
            r_flip[k] <= r_flip[k-1];
        end
    end

    always_comb begin
        c1 = rot_d[0][gcd_pkg::NSTEPS].x;
        c2 = rot_d[1][gcd_pkg::NSTEPS].x;
        sa = rot_d[2][gcd_pkg::NSTEPS].y;
        sb = rot_d[3][gcd_pkg::NSTEPS].y;
        negc1 = r_flip[gcd_pkg::NSTEPS-1][0] ? (!c1[CW-1] && (c1 != '0)) : c1[CW-1];
        negc2 = r_flip[gcd_pkg::NSTEPS-1][1] ? (!c2[CW-1] && (c2 != '0)) : c2[CW-1];
        n_neg0 = negc1 ^ negc2;
        n_mc1 = c1[CW-1] ? 32'(-c1) : c1[31:0];
        n_mc2 = c2[CW-1] ? 32'(-c2) : c2[31:0];
        n_msa = sa[CW-1] ? 32'(-sa) : sa[31:0];
        n_msb = sb[CW-1] ? 32'(-sb) : sb[31:0];

        n_s1sq1 = 64'(r_msa) * 64'(r_msa);
        n_ccf   = 64'(r_mc1) * 64'(r_mc2);

        t1p  = 64'(r_ccf[61:30]) * 64'(r_sbm1);
        n_t1 = t1p[61:30];

        n_term = 64'(r_t1) * 64'(r_sbm2);

        if (r_neg3) begin
            hs = $signed({2'b00, r_s1sq3}) - $signed({2'b00, r_term});
        end else begin
            hs = $signed({2'b00, r_s1sq3}) + $signed({2'b00, r_term});
        end
        if (hs[65]) begin
            n_h = '0;
        end else if (hs > $signed(66'(gcd_pkg::ONE_Q60))) begin
            n_h = gcd_pkg::ONE_Q60;
        end else begin
            n_h = hs[60:0];
        end

        n_ny = gcd_pkg::SQW'(r_h);
        n_nx = gcd_pkg::SQW'(gcd_pkg::ONE_Q60 - r_h);
    end

    always_ff @(posedge i_clk) begin
        r_mc1   <= n_mc1;
        r_mc2   <= n_mc2;
        r_msa   <= n_msa;
        r_msb   <= n_msb;
        r_neg0  <= n_neg0;
        r_s1sq1 <= n_s1sq1;
        r_ccf   <= n_ccf;
        r_sbm1  <= r_msb;
        r_neg1  <= r_neg0;
        r_t1    <= n_t1;
        r_s1sq2 <= r_s1sq1;
        r_sbm2  <= r_sbm1;
        r_neg2  <= r_neg1;
        r_term  <= n_term;
        r_s1sq3 <= r_s1sq2;
        r_neg3  <= r_neg2;
        r_h     <= n_h;
        r_ny    <= n_ny;
        r_nx    <= n_nx;
    end

    always_comb begin
        sq_y[0].n = r_ny;
        sq_y[0].r = '0;
        sq_x[0].n = r_nx;
        sq_x[0].r = '0;
    end

    for (genvar k = 0; k < gcd_pkg::SQRT_STEPS; k++) begin : g_sqrt
        gcd_sqrt_cell u_sqy (
            .i_clk (i_clk),
            .i_step(5'(gcd_pkg::SQRT_STEPS - 1 - k)),
            .i_data(sq_y[k]),
            .o_data(sq_y[k+1])
        );
        gcd_sqrt_cell u_sqx (
            .i_clk (i_clk),
            .i_step(5'(gcd_pkg::SQRT_STEPS - 1 - k)),
            .i_data(sq_x[k]),
            .o_data(sq_x[k+1])
        );
    end

    always_comb begin
        vec_d[0].x = {{(CW-31){1'b0}}, sq_x[gcd_pkg::SQRT_STEPS].r[30:0]};
        vec_d[0].y = {{(CW-31){1'b0}}, sq_y[gcd_pkg::SQRT_STEPS].r[30:0]};
        vec_d[0].z = '0;
    end

    for (genvar k = 0; k < gcd_pkg::NSTEPS; k++) begin : g_vec
        gcd_cordic_cell u_cell (
            .i_clk      (i_clk),
            .i_vectoring(1'b1),
            .i_shift    (5'(k)),
            .i_atan     (gcd_pkg::ATAN_TAB[k]),
            .i_data     (vec_d[k]),
            .o_data     (vec_d[k+1])
        );
    end

    always_comb begin
        zv = vec_d[gcd_pkg::NSTEPS].z;
        if (zv[CW-1]) begin
            zc = '0;
        end else if (zv > $signed(CW'(31'h4000_0000))) begin
            zc = 31'h4000_0000;
        end else begin
            zc = zv[30:0];
        end
        n_prod = 62'(zc) * 62'(gcd_pkg::CIRC_X4);
        fsum   = r_prod + {29'd0, 1'b1, 32'd0};
        n_dist = fsum[60:33];
        n_vld  = {r_vld[gcd_pkg::LAT-2:0], start & !busy};
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_dist <= n_dist;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_valid    = r_vld[gcd_pkg::LAT-1];
    assign o_distance = r_dist;

    `ASSERT_IMPLIES(a_dist_bound, i_clk, i_rst_n, o_valid, o_distance <= gcd_pkg::DIST_MAX)
    `ASSERT_IMPLIES(a_root_bound, i_clk, i_rst_n, r_vld[gcd_pkg::SQRT_DONE], (sq_y[gcd_pkg::SQRT_STEPS].r <= gcd_pkg::ROOT_MAX) && (sq_x[gcd_pkg::SQRT_STEPS].r <= gcd_pkg::ROOT_MAX))

endmodule
